// ===== rtl/esvr_pkg.sv =====
package esvr_pkg;

    // widths of the stream fields
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned VALUE_W   = 10;
    localparam int unsigned PART_W    = 6;
    localparam int unsigned ACTION_W  = 2;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 16;
    localparam int unsigned S_DATA_W  = 40;
    localparam int unsigned M_DATA_W  = 24;
    localparam int unsigned RES_MAX   = 3;

    // counter limit and decoder scaling
    localparam logic [VALUE_W-1:0] VALUE_MAX            = 10'd999;
    localparam logic signed [4:0]  QUAD_STEPS_PER_COUNT = 5'sd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SHAKE_DEBOUNCE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHAKE_WINDOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHAKE_THRESH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHAKE_COOLDOWN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BUTTON_LOCKOUT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ENCODER_HOLD   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CONTRAST_PER   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FLASH_PER      = 3'd7;

    // register reset values
    localparam logic [15:0] RST_SHAKE_DEBOUNCE = 16'd80;
    localparam logic [15:0] RST_SHAKE_WINDOW   = 16'd1000;
    localparam logic [7:0]  RST_SHAKE_THRESH   = 8'd6;
    localparam logic [15:0] RST_SHAKE_COOLDOWN = 16'd500;
    localparam logic [15:0] RST_BUTTON_LOCKOUT = 16'd300;
    localparam logic [15:0] RST_ENCODER_HOLD   = 16'd200;
    localparam logic [5:0]  RST_CONTRAST_PER   = 6'd20;
    localparam logic [5:0]  RST_FLASH_PER      = 6'd3;

    // refresh actions
    localparam logic [ACTION_W-1:0] ACT_FULL     = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PARTIAL  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FLASH    = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_CONTRAST = 2'd3;

    // quadrature step per (previous, current) pair of A/B levels
    localparam logic signed [1:0] QUAD_TABLE [16] = '{
        2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd1, 2'sd0, 2'sd0, -2'sd1,
        -2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd0
    };

    typedef struct packed {
        logic              shake_level;
        logic              button_level;
        logic              enc_b;
        logic              enc_a;
        logic [TIME_W-1:0] now_ms;
    } sample_t;

    typedef struct packed {
        logic [PART_W-1:0]   partial_number;
        logic [VALUE_W-1:0]  shown_value;
        logic [ACTION_W-1:0] action;
    } result_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [PART_W-1:0]   partial_count;
        logic [PART_W-1:0]   flash_phase;
    } recovery_t;

endpackage

// ===== rtl/encoder_shake_value_refresh_ctrl.sv =====
// channel   | ports                       | payload
// ----------+-----------------------------+------------------------------------------
// sample in | s_tvalid s_tready s_tdata   | now_ms, enc_a, enc_b, button_level, shake_level
// refresh   | m_tvalid m_tready m_tdata   | action, shown_value, partial_number; tlast = last
//           | m_tlast                     |
// config    | cfg_we cfg_index cfg_wdata  | eight registers, write only
//
// a sample is held in the input register, then is decoded in one pass
// and its 0..3 refreshes land in a three-entry result buffer, drained one per cycle
// whenever m_tready is high; a sample with no refreshes is decoded while the buffer drains
// aresetn is synchronous, active low; clears control state and restores register defaults
// a stalled result buffer holds the decoded sample in the input register

module encoder_shake_value_refresh_ctrl #(
    parameter logic [esvr_pkg::VALUE_W-1:0] VALUE_MAX            = esvr_pkg::VALUE_MAX,
    parameter logic signed [4:0]            QUAD_STEPS_PER_COUNT =
                                                esvr_pkg::QUAD_STEPS_PER_COUNT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [31:0] now_ms, [32] enc_a, [33] enc_b, [34] button_level, [35] shake_level
    input  logic [esvr_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [1:0] action, [11:2] shown_value, [17:12] partial_number
    output logic [esvr_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [esvr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [esvr_pkg::CFG_DAT_W-1:0]  cfg_wdata
);

    // configuration registers
    logic [15:0] shake_debounce_reg;
    logic [15:0] shake_window_reg;
    logic [7:0]  shake_thresh_reg;
    logic [15:0] shake_cooldown_reg;
    logic [15:0] button_lockout_reg;
    logic [15:0] encoder_hold_reg;
    logic [5:0]  contrast_per_reg;
    logic [5:0]  flash_per_reg;

    // input register
    esvr_pkg::sample_t in_reg;
    logic              in_vld_reg;

    // decoder state
    logic [1:0]        last_quad_reg,     last_quad_next;
    logic signed [3:0] quad_steps_reg,    quad_steps_next;
    logic signed [7:0] pending_reg,       pending_next;
    logic              prev_button_reg,   prev_button_next;
    logic [31:0]       button_accept_reg, button_accept_next;
    logic              prev_shake_reg,    prev_shake_next;
    logic [31:0]       shake_accept_reg,  shake_accept_next;
    logic [31:0]       enc_apply_reg,     enc_apply_next;
    logic [7:0]        shake_count_reg,   shake_count_next;
    logic [31:0]       window_start_reg,  window_start_next;
    logic [31:0]       shake_action_reg,  shake_action_next;
    logic [9:0]        counter_reg,       counter_next;
    logic [5:0]        partial_reg,       partial_next;
    logic [5:0]        flash_phase_reg,   flash_phase_next;

    // result buffer, entry 0 is the head
    esvr_pkg::result_t res_reg [esvr_pkg::RES_MAX];
    esvr_pkg::result_t res_next [esvr_pkg::RES_MAX];
    logic [1:0]        cnt_reg, cnt_next;

    // per-sample decode
    esvr_pkg::result_t   res_btn, res_enc, res_shk;
    esvr_pkg::recovery_t rec_enc, rec_shk;
    logic                press, shake_edge, enc_fire, shk_fire;
    logic [1:0]          n_res;
    logic                buf_free, proc;

    // one partial refresh step of the recovery counters
    function automatic esvr_pkg::recovery_t partial_step(
        input logic [5:0] pc,
        input logic [5:0] fp,
        input logic [5:0] cper,
        input logic [5:0] fper
    );
        esvr_pkg::recovery_t r;
        logic [5:0]          pc1;
        logic [5:0]          fp1;
        pc1 = pc + 6'd1;
        fp1 = fp + 6'd1;
        if (pc1 >= cper) begin
            r.partial_count = '0;
            r.flash_phase   = '0;
            r.action        = esvr_pkg::ACT_CONTRAST;
        end else if (fp1 >= fper) begin
            r.partial_count = pc1;
            r.flash_phase   = '0;
            r.action        = esvr_pkg::ACT_FLASH;
        end else begin
            r.partial_count = pc1;
            r.flash_phase   = fp1;
            r.action        = esvr_pkg::ACT_PARTIAL;
        end
        return r;
    endfunction

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shake_debounce_reg <= esvr_pkg::RST_SHAKE_DEBOUNCE;
            shake_window_reg   <= esvr_pkg::RST_SHAKE_WINDOW;
            shake_thresh_reg   <= esvr_pkg::RST_SHAKE_THRESH;
            shake_cooldown_reg <= esvr_pkg::RST_SHAKE_COOLDOWN;
            button_lockout_reg <= esvr_pkg::RST_BUTTON_LOCKOUT;
            encoder_hold_reg   <= esvr_pkg::RST_ENCODER_HOLD;
            contrast_per_reg   <= esvr_pkg::RST_CONTRAST_PER;
            flash_per_reg      <= esvr_pkg::RST_FLASH_PER;
        end else if (cfg_we) begin
            case (cfg_index)
                esvr_pkg::REG_SHAKE_DEBOUNCE: shake_debounce_reg <= cfg_wdata;
                esvr_pkg::REG_SHAKE_WINDOW:   shake_window_reg   <= cfg_wdata;
                esvr_pkg::REG_SHAKE_THRESH:   shake_thresh_reg   <= cfg_wdata[7:0];
                esvr_pkg::REG_SHAKE_COOLDOWN: shake_cooldown_reg <= cfg_wdata;
                esvr_pkg::REG_BUTTON_LOCKOUT: button_lockout_reg <= cfg_wdata;
                esvr_pkg::REG_ENCODER_HOLD:   encoder_hold_reg   <= cfg_wdata;
                esvr_pkg::REG_CONTRAST_PER:   contrast_per_reg   <= cfg_wdata[5:0];
                esvr_pkg::REG_FLASH_PER:      flash_per_reg      <= cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    // handshake: decode goes ahead when it has no refreshes or the result buffer is empty or popping its last entry
    assign buf_free = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);
    assign proc     = in_vld_reg && ((n_res == 2'd0) || buf_free);
    assign s_tready = !in_vld_reg || proc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_reg <= esvr_pkg::sample_t'(s_tdata[35:0]);
        end
    end

    // single-pass decode of the registered sample
    always_comb begin
        logic signed [4:0]  qs_sum;
        logic [31:0]        d_btn, d_shk, d_enc, d_act, d_win;
        logic signed [11:0] v_sum;
        logic [9:0]         cv_enc;
        logic [5:0]         pc0, fp0, pc1, fp1;
        logic [7:0]         sc;
        logic [31:0]        ws;

        // quadrature
        qs_sum = {quad_steps_reg[3], quad_steps_reg}
               + 5'(esvr_pkg::QUAD_TABLE[{last_quad_reg, in_reg.enc_a, in_reg.enc_b}]);
        last_quad_next  = {in_reg.enc_a, in_reg.enc_b};
        quad_steps_next = qs_sum[3:0];
        pending_next    = pending_reg;
        if (qs_sum >= QUAD_STEPS_PER_COUNT) begin
            if (pending_reg != -8'sd128) pending_next = pending_reg - 8'sd1;
            quad_steps_next = '0;
        end else if (qs_sum <= -QUAD_STEPS_PER_COUNT) begin
            if (pending_reg != 8'sd127) pending_next = pending_reg + 8'sd1;
            quad_steps_next = '0;
        end

        // button edge with lockout
        d_btn              = in_reg.now_ms - button_accept_reg;
        press              = prev_button_reg && !in_reg.button_level
                             && (d_btn >= {16'd0, button_lockout_reg});
        button_accept_next = press ? in_reg.now_ms : button_accept_reg;
        prev_button_next   = in_reg.button_level;

        // shake edge with debounce
        d_shk             = in_reg.now_ms - shake_accept_reg;
        shake_edge        = prev_shake_reg && !in_reg.shake_level
                            && (d_shk >= {16'd0, shake_debounce_reg});
        shake_accept_next = shake_edge ? in_reg.now_ms : shake_accept_reg;
        prev_shake_next   = in_reg.shake_level;

        // forced full refresh clears the recovery counters
        pc0 = press ? 6'd0 : partial_reg;
        fp0 = press ? 6'd0 : flash_phase_reg;
        res_btn.action         = esvr_pkg::ACT_FULL;
        res_btn.shown_value    = counter_reg;
        res_btn.partial_number = 6'd0;

        // pending counts applied after the hold time
        d_enc    = in_reg.now_ms - enc_apply_reg;
        enc_fire = (pending_next != 8'sd0) && (d_enc >= {16'd0, encoder_hold_reg});
        v_sum    = $signed({2'b00, counter_reg}) + 12'(pending_next);
        if (v_sum < 12'sd0) begin
            cv_enc = '0;
        end else if (v_sum > $signed({2'b00, VALUE_MAX})) begin
            cv_enc = VALUE_MAX;
        end else begin
            cv_enc = v_sum[9:0];
        end
        rec_enc = partial_step(pc0, fp0, contrast_per_reg, flash_per_reg);
        res_enc.action         = rec_enc.action;
        res_enc.shown_value    = cv_enc;
        res_enc.partial_number = rec_enc.partial_count;
        if (enc_fire) begin
            pending_next   = '0;
            counter_next   = cv_enc;
            pc1            = rec_enc.partial_count;
            fp1            = rec_enc.flash_phase;
            enc_apply_next = in_reg.now_ms;
        end else begin
            counter_next   = counter_reg;
            pc1            = pc0;
            fp1            = fp0;
            enc_apply_next = enc_apply_reg;
        end

        // shake window counting with cooldown
        d_act             = in_reg.now_ms - shake_action_reg;
        d_win             = in_reg.now_ms - window_start_reg;
        sc                = shake_count_reg;
        ws                = window_start_reg;
        shk_fire          = 1'b0;
        shake_action_next = shake_action_reg;
        if (shake_edge && (d_act > {16'd0, shake_cooldown_reg})) begin
            if ((sc == 8'd0) || (d_win > {16'd0, shake_window_reg})) begin
                sc = 8'd1;
                ws = in_reg.now_ms;
            end else if (sc != 8'd255) begin
                sc = sc + 8'd1;
            end
            if (sc >= shake_thresh_reg) begin
                shk_fire          = 1'b1;
                shake_action_next = in_reg.now_ms;
                sc                = 8'd0;
            end
        end
        rec_shk = partial_step(pc1, fp1, contrast_per_reg, flash_per_reg);
        res_shk.action         = rec_shk.action;
        res_shk.shown_value    = (counter_next == VALUE_MAX)
                                 ? counter_next : counter_next + 10'd1;
        res_shk.partial_number = rec_shk.partial_count;
        if (shk_fire) begin
            counter_next     = res_shk.shown_value;
            partial_next     = rec_shk.partial_count;
            flash_phase_next = rec_shk.flash_phase;
        end else begin
            partial_next     = pc1;
            flash_phase_next = fp1;
        end

        // window expiry, once per sample
        if ((sc != 8'd0) && ((in_reg.now_ms - ws) > {16'd0, shake_window_reg})) begin
            sc = 8'd0;
        end
        shake_count_next  = sc;
        window_start_next = ws;

        n_res = 2'(press) + 2'(enc_fire) + 2'(shk_fire);
    end

    // decoder state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_quad_reg     <= 2'b11;
            quad_steps_reg    <= '0;
            pending_reg       <= '0;
            prev_button_reg   <= 1'b1;
            button_accept_reg <= '0;
            prev_shake_reg    <= 1'b1;
            shake_accept_reg  <= '0;
            enc_apply_reg     <= '0;
            shake_count_reg   <= '0;
            window_start_reg  <= '0;
            shake_action_reg  <= '0;
            counter_reg       <= '0;
            partial_reg       <= '0;
            flash_phase_reg   <= '0;
        end else if (proc) begin
            last_quad_reg     <= last_quad_next;
            quad_steps_reg    <= quad_steps_next;
            pending_reg       <= pending_next;
            prev_button_reg   <= prev_button_next;
            button_accept_reg <= button_accept_next;
            prev_shake_reg    <= prev_shake_next;
            shake_accept_reg  <= shake_accept_next;
            enc_apply_reg     <= enc_apply_next;
            shake_count_reg   <= shake_count_next;
            window_start_reg  <= window_start_next;
            shake_action_reg  <= shake_action_next;
            counter_reg       <= counter_next;
            partial_reg       <= partial_next;
            flash_phase_reg   <= flash_phase_next;
        end
    end

    // result buffer: load in order button, encoder, shake; otherwise shift on pop
    always_comb begin
        res_next = res_reg;
        cnt_next = cnt_reg;
        if (proc && (n_res != 2'd0)) begin
            res_next[0] = press ? res_btn : (enc_fire ? res_enc : res_shk);
            res_next[1] = (press && enc_fire) ? res_enc : res_shk;
            res_next[2] = res_shk;
            cnt_next    = n_res;
        end else if (m_tvalid && m_tready) begin
            res_next[0] = res_reg[1];
            res_next[1] = res_reg[2];
            cnt_next    = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tlast  = (cnt_reg == 2'd1);
    assign m_tdata  = {6'd0, res_reg[0]};

    // checks
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 2'd3)
        else $error("result buffer count out of range");

    a_value_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (res_reg[0].shown_value <= VALUE_MAX))
        else $error("shown value above limit");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && !proc) |=> (in_vld_reg && $stable(in_reg)))
        else $error("held sample lost while result buffer busy");

    a_counter_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        counter_reg <= VALUE_MAX)
        else $error("counter above limit");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

// keeps its own copy of the controller state and the register file, works out
// the refreshes of every accepted sample and checks them in order
class refresh_scoreboard;

    localparam int STEPS_PER_COUNT = 4;
    localparam int VALUE_LIMIT     = 999;

    typedef struct packed {
        logic                last;
        esvr_pkg::result_t   fields;
    } refresh_t;

    // quadrature step per {previous A/B, current A/B}
    int step_of [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};

    // register copy
    logic [15:0] debounce_ms, window_ms, cooldown_ms, lockout_ms, hold_ms;
    logic [7:0]  threshold;
    logic [5:0]  contrast_per, flash_per;

    // controller state copy
    logic [1:0]        last_quad;
    logic signed [3:0] quad_steps;
    logic signed [7:0] pending;
    logic              prev_button, prev_shake;
    logic [31:0]       button_ms, shake_ms, apply_ms, window_start, shake_action_ms;
    logic [7:0]        shake_count;
    logic [9:0]        value;
    logic [5:0]        partial_count, flash_phase;

    refresh_t    due_refreshes [$];
    int unsigned errors;

    function new();
        debounce_ms     = 16'd80;
        window_ms       = 16'd1000;
        threshold       = 8'd6;
        cooldown_ms     = 16'd500;
        lockout_ms      = 16'd300;
        hold_ms         = 16'd200;
        contrast_per    = 6'd20;
        flash_per       = 6'd3;
        last_quad       = 2'b11;
        quad_steps      = '0;
        pending         = '0;
        prev_button     = 1'b1;
        prev_shake      = 1'b1;
        button_ms       = '0;
        shake_ms        = '0;
        apply_ms        = '0;
        window_start    = '0;
        shake_action_ms = '0;
        shake_count     = '0;
        value           = '0;
        partial_count   = '0;
        flash_phase     = '0;
        errors          = 0;
    endfunction

    function void write_reg(logic [esvr_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
        case (idx)
            esvr_pkg::REG_SHAKE_DEBOUNCE: debounce_ms  = data;
            esvr_pkg::REG_SHAKE_WINDOW:   window_ms    = data;
            esvr_pkg::REG_SHAKE_THRESH:   threshold    = data[7:0];
            esvr_pkg::REG_SHAKE_COOLDOWN: cooldown_ms  = data;
            esvr_pkg::REG_BUTTON_LOCKOUT: lockout_ms   = data;
            esvr_pkg::REG_ENCODER_HOLD:   hold_ms      = data;
            esvr_pkg::REG_CONTRAST_PER:   contrast_per = data[5:0];
            esvr_pkg::REG_FLASH_PER:      flash_per    = data[5:0];
            default: ;
        endcase
    endfunction

    // one partial refresh: contrast recovery wins over the flash spacing
    function logic [1:0] next_partial();
        partial_count = partial_count + 6'd1;
        if (partial_count >= contrast_per) begin
            partial_count = '0;
            flash_phase   = '0;
            return esvr_pkg::ACT_CONTRAST;
        end
        flash_phase = flash_phase + 6'd1;
        if (flash_phase >= flash_per) begin
            flash_phase = '0;
            return esvr_pkg::ACT_FLASH;
        end
        return esvr_pkg::ACT_PARTIAL;
    endfunction

    function refresh_t make_refresh(logic [1:0] act);
        refresh_t r;
        r.last                  = 1'b0;
        r.fields.action         = act;
        r.fields.shown_value    = value;
        r.fields.partial_number = partial_count;
        return r;
    endfunction

    // accepted sample: advance the state and queue the refreshes it causes
    function void take_sample(esvr_pkg::sample_t smp);
        logic [31:0] now;
        logic [31:0] gap;
        logic [1:0]  quad;
        logic [1:0]  act;
        logic        press;
        logic        shake;
        int          v;
        int          n;
        refresh_t    batch [3];
        now   = smp.now_ms;
        quad  = {smp.enc_a, smp.enc_b};
        press = 1'b0;
        shake = 1'b0;
        n     = 0;

        quad_steps = 4'(quad_steps + step_of[{last_quad, quad}]);
        last_quad  = quad;
        if (quad_steps >= STEPS_PER_COUNT) begin
            if (pending > -128) pending = pending - 8'sd1;
            quad_steps = '0;
        end else if (quad_steps <= -STEPS_PER_COUNT) begin
            if (pending < 127) pending = pending + 8'sd1;
            quad_steps = '0;
        end

        gap = now - button_ms;
        if (prev_button && !smp.button_level && gap >= {16'd0, lockout_ms}) begin
            button_ms = now;
            press     = 1'b1;
        end
        prev_button = smp.button_level;

        gap = now - shake_ms;
        if (prev_shake && !smp.shake_level && gap >= {16'd0, debounce_ms}) begin
            shake_ms = now;
            shake    = 1'b1;
        end
        prev_shake = smp.shake_level;

        if (press) begin
            partial_count = '0;
            flash_phase   = '0;
            batch[n]      = make_refresh(esvr_pkg::ACT_FULL);
            n++;
        end

        gap = now - apply_ms;
        if (pending != 0 && gap >= {16'd0, hold_ms}) begin
            v       = int'(value) + int'(pending);
            pending = '0;
            if (v < 0) v = 0;
            if (v > VALUE_LIMIT) v = VALUE_LIMIT;
            value    = 10'(v);
            act      = next_partial();
            batch[n] = make_refresh(act);
            n++;
            apply_ms = now;
        end

        gap = now - shake_action_ms;
        if (shake && gap > {16'd0, cooldown_ms}) begin
            gap = now - window_start;
            if (shake_count == 0 || gap > {16'd0, window_ms}) begin
                shake_count  = 8'd1;
                window_start = now;
            end else if (shake_count < 8'd255) begin
                shake_count = shake_count + 8'd1;
            end
            if (shake_count >= threshold) begin
                v = int'(value) + 1;
                if (v > VALUE_LIMIT) v = VALUE_LIMIT;
                value           = 10'(v);
                act             = next_partial();
                batch[n]        = make_refresh(act);
                n++;
                shake_action_ms = now;
                shake_count     = '0;
            end
        end

        gap = now - window_start;
        if (shake_count > 0 && gap > {16'd0, window_ms}) shake_count = '0;

        if (n > 0) batch[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) due_refreshes.push_back(batch[i]);
    endfunction

    function void check_refresh(esvr_pkg::result_t got, logic got_last);
        refresh_t want;
        if (due_refreshes.size() == 0) begin
            $error("refresh with no expectation: action %0d value %0d partial %0d",
                   got.action, got.shown_value, got.partial_number);
            errors++;
            return;
        end
        want = due_refreshes.pop_front();
        if (got.action !== want.fields.action) begin
            $error("action: expected %0d, actual %0d", want.fields.action, got.action);
            errors++;
        end
        if (got.shown_value !== want.fields.shown_value) begin
            $error("shown_value: expected %0d, actual %0d",
                   want.fields.shown_value, got.shown_value);
            errors++;
        end
        if (got.partial_number !== want.fields.partial_number) begin
            $error("partial_number: expected %0d, actual %0d",
                   want.fields.partial_number, got.partial_number);
            errors++;
        end
        if (got_last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got_last);
            errors++;
        end
    endfunction

endclass

module tb_top;

    // cycles with no transaction on either channel before the run is abandoned
    localparam int WATCHDOG_LIMIT = 2000;
    // settle time after the last expected refresh, covers samples with no refresh
    localparam int SETTLE_CYCLES  = 8;

    // register write order, index by name
    localparam logic [esvr_pkg::CFG_IDX_W-1:0] REG_ORDER [8] = '{
        esvr_pkg::REG_SHAKE_DEBOUNCE, esvr_pkg::REG_SHAKE_WINDOW,
        esvr_pkg::REG_SHAKE_THRESH,   esvr_pkg::REG_SHAKE_COOLDOWN,
        esvr_pkg::REG_BUTTON_LOCKOUT, esvr_pkg::REG_ENCODER_HOLD,
        esvr_pkg::REG_CONTRAST_PER,   esvr_pkg::REG_FLASH_PER
    };

    // encoder position to A/B levels, walking upwards is a positive step
    localparam logic [1:0] GRAY_CODE [4] = '{2'b11, 2'b01, 2'b00, 2'b10};

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    // [31:0] now_ms, [32] enc_a, [33] enc_b, [34] button_level, [35] shake_level
    logic [esvr_pkg::S_DATA_W-1:0]  s_tdata   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b1;
    // [1:0] action, [11:2] shown_value, [17:12] partial_number
    logic [esvr_pkg::M_DATA_W-1:0]  m_tdata;
    logic                           m_tlast;
    logic                           cfg_we    = 1'b0;
    logic [esvr_pkg::CFG_IDX_W-1:0] cfg_index = esvr_pkg::REG_SHAKE_DEBOUNCE;
    logic [esvr_pkg::CFG_DAT_W-1:0] cfg_wdata = '0;

    refresh_scoreboard sb = new();

    // pin model of the stimulus
    logic [31:0] cur_ms    = '0;
    int          enc_pos   = 0;
    int          enc_dir   = 1;
    logic        btn_lvl   = 1'b1;
    logic        shk_lvl   = 1'b1;

    // idling control and watchdog
    bit          src_idle_en  = 1'b1;
    bit          sink_idle_en = 1'b1;
    int          stall_left   = 0;
    int          idle_cycles  = 0;

    encoder_shake_value_refresh_ctrl dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    // receiver back-pressure: random stall bursts, none once switched off
    always @(negedge aclk) begin
        if (!sink_idle_en) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready  <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // refresh monitor and activity count for the watchdog
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_refresh(esvr_pkg::result_t'(m_tdata[17:0]), m_tlast);
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("tb_top: errors");
        $finish;
    end

    // next sample: time moves on by dt, encoder moves by mv positions
    function esvr_pkg::sample_t pin_sample(logic [31:0] dt, int mv, logic btn, logic shk);
        esvr_pkg::sample_t smp;
        cur_ms           = cur_ms + dt;
        enc_pos          = (enc_pos + mv + 4) % 4;
        btn_lvl          = btn;
        shk_lvl          = shk;
        smp.now_ms       = cur_ms;
        smp.enc_a        = GRAY_CODE[enc_pos][1];
        smp.enc_b        = GRAY_CODE[enc_pos][0];
        smp.button_level = btn;
        smp.shake_level  = shk;
        return smp;
    endfunction

    // mostly a well-formed turn of the knob with button and shake activity,
    // sometimes a skipped encoder state or a wild jump in time
    function esvr_pkg::sample_t roll_sample();
        logic [31:0] dt;
        int          mv;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)      dt = $urandom_range(1, 120);
        else if (pick < 80) dt = $urandom_range(100, 700);
        else if (pick < 90) dt = $urandom_range(0, 3);
        else if (pick < 95) dt = $urandom_range(60000, 70000);
        else                dt = $urandom();
        if ($urandom_range(0, 9) == 0) enc_dir = -enc_dir;
        pick = $urandom_range(0, 9);
        if (pick < 7)       mv = enc_dir;
        else if (pick < 9)  mv = 0;
        else                mv = 2;
        return pin_sample(dt, mv,
                          ($urandom_range(0, 9) < 3) ? ~btn_lvl : btn_lvl,
                          ($urandom_range(0, 9) < 6) ? ~shk_lvl : shk_lvl);
    endfunction

    // one sample transaction, with an optional gap in front of it
    task automatic send_sample(input esvr_pkg::sample_t smp);
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= esvr_pkg::S_DATA_W'(smp);
        do @(posedge aclk); while (!s_tready);
        sb.take_sample(smp);
        @(negedge aclk);
    endtask

    // sender holds off until every expected refresh is out and the block is quiet
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.due_refreshes.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic program_regs(input logic [15:0] debounce, input logic [15:0] window,
                                input logic [15:0] thresh, input logic [15:0] cooldown,
                                input logic [15:0] lockout, input logic [15:0] hold,
                                input logic [15:0] contrast, input logic [15:0] flash);
        logic [15:0] vals [8];
        vals = '{debounce, window, thresh, cooldown, lockout, hold, contrast, flash};
        wait_drained();
        for (int i = 0; i < 8; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_ORDER[i];
            cfg_wdata <= vals[i];
            sb.write_reg(REG_ORDER[i], vals[i]);
            @(negedge aclk);
        end
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++) begin
            // now and then the sender waits for the result side to empty
            if ($urandom_range(0, 29) == 0) wait_drained();
            send_sample(roll_sample());
        end
    endtask

    // many encoder steps one way, then one late sample to apply the pending count
    task automatic turn_and_apply(input int mv, input int steps);
        for (int i = 0; i < steps; i++) send_sample(pin_sample(32'd1, mv, 1'b1, 1'b1));
        send_sample(pin_sample(32'd65536, 0, 1'b1, 1'b1));
    endtask

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed, reset register values
        send_sample(pin_sample(32'd0, 0, 1'b1, 1'b1));
        // four steps up remove one count; hold time not yet over
        repeat (4) send_sample(pin_sample(32'd10, 1, 1'b1, 1'b1));
        // applied after the hold, clamps at zero
        send_sample(pin_sample(32'd200, 0, 1'b1, 1'b1));
        // four steps down add one count
        repeat (4) send_sample(pin_sample(32'd10, -1, 1'b1, 1'b1));
        // button press and pending count in one sample
        send_sample(pin_sample(32'd300, 0, 1'b0, 1'b1));
        // second press inside the lockout is dropped
        send_sample(pin_sample(32'd10, 0, 1'b1, 1'b1));
        send_sample(pin_sample(32'd10, 0, 1'b0, 1'b1));
        send_sample(pin_sample(32'd10, 0, 1'b1, 1'b1));

        // threshold, contrast and flash period zero: press, encoder and shake at once
        program_regs(16'd0, 16'd1000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        repeat (3) send_sample(pin_sample(32'd5, 1, 1'b1, 1'b1));
        send_sample(pin_sample(32'd5, 1, 1'b0, 1'b0));

        // flash on every partial, short window and debounce
        program_regs(16'd30, 16'd50, 16'd2, 16'd10, 16'd0, 16'd0, 16'd63, 16'd0);
        send_sample(pin_sample(32'd5, 0, 1'b1, 1'b1));
        send_sample(pin_sample(32'd40, 0, 1'b1, 1'b0));
        send_sample(pin_sample(32'd5, 0, 1'b1, 1'b1));
        // shake edge inside the debounce
        send_sample(pin_sample(32'd10, 0, 1'b1, 1'b0));
        send_sample(pin_sample(32'd5, 0, 1'b1, 1'b1));
        // window ran out, counting restarts
        send_sample(pin_sample(32'd100, 0, 1'b1, 1'b0));
        send_sample(pin_sample(32'd5, 0, 1'b1, 1'b1));
        // another shake edge inside the window brings the count to the threshold
        send_sample(pin_sample(32'd35, 0, 1'b1, 1'b0));
        // time wraps past zero
        send_sample(pin_sample(32'hFFFF_FFF0 - cur_ms, 0, 1'b1, 1'b1));
        send_sample(pin_sample(32'd32, 1, 1'b0, 1'b1));

        // random, mid-range settings
        program_regs(16'd20, 16'd2000, 16'd3, 16'd100, 16'd50, 16'd0, 16'd5, 16'd2);
        run_random(15);

        // long hold: pending counts build up both ways and are applied late
        program_regs(16'd80, 16'd1000, 16'd6, 16'd500, 16'd300, 16'd65535, 16'd20, 16'd3);
        src_idle_en = 1'b0;
        turn_and_apply(1, 12);
        turn_and_apply(-1, 20);
        src_idle_en = 1'b1;
        run_random(10);

        // every shake counts, flash period one
        program_regs(16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd63, 16'd1);
        run_random(15);

        // upper extremes
        program_regs(16'hFFFF, 16'hFFFF, 16'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     16'd63, 16'd63);
        run_random(15);

        // random settings
        program_regs(16'($urandom_range(0, 400)), 16'($urandom_range(0, 3000)),
                     16'($urandom_range(0, 8)), 16'($urandom_range(0, 800)),
                     16'($urandom_range(0, 600)), 16'($urandom_range(0, 400)),
                     16'($urandom_range(0, 63)), 16'($urandom_range(0, 63)));
        run_random(15);

        // reset values written back, no idling on either side
        program_regs(16'd80, 16'd1000, 16'd6, 16'd500, 16'd300, 16'd200, 16'd20, 16'd3);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        run_random(20);

        wait_drained();
        repeat (20) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
